// ----- sv/gol_pkg.sv -----
// ----------------------------------------------------------------------------
// gol_pkg
// Shared types and constants for the life grid generation step.
// ----------------------------------------------------------------------------
package gol_pkg;

    // grid size
    localparam int GRID_W = 64;
    localparam int GRID_H = 64;

    localparam int ADDR_W = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int CNT_W  = $clog2(GRID_H + 1);

    // stream field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int DATA_W  = 64;
    localparam int TDATA_W = ((DATA_W + IDX_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH,
        ST_READ,
        ST_HOLD
    } state_t;

endpackage

// ----- sv/life_grid_generation_step.sv -----
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Life grid (B3/S23), one memory word per row: load row, read row, advance.
// Throughput: one word in flight; the next word is taken when the result can
// leave. An advance sweeps each row once through the row memory read port.
// Reset: asynchronous; per-row valid bits clear so the whole grid reads dead.
// ----------------------------------------------------------------------------
module life_grid_generation_step
    import gol_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // row_index[5:0], row_bits[69:6], zero pad
    input  logic [OP_W-1:0]    s_tuser,  // operation[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // row_data[63:0], row_echo[69:64], zero pad
    output logic [OP_W-1:0]    m_tuser   // done_kind[1:0]
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [GRID_W-1:0]  above_reg, above_next;
    logic [GRID_W-1:0]  here_reg, here_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]  wr_addr_reg, wr_addr_next;
    logic               rd_ok_reg;
    logic [GRID_W-1:0]  rd_q_reg;
    logic [GRID_H-1:0]  valid_reg;

    logic [GRID_W-1:0]  mem [GRID_H];

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [GRID_W-1:0]  wr_data;

    logic [GRID_W-1:0]  res_data_reg, res_data_next;
    logic [IDX_W-1:0]   res_echo_reg, res_echo_next;
    logic [OP_W-1:0]    res_kind_reg, res_kind_next;

    logic               m_valid_reg, m_valid_next;
    logic [GRID_W-1:0]  m_data_reg, m_data_next;
    logic [IDX_W-1:0]   m_echo_reg, m_echo_next;
    logic [OP_W-1:0]    m_kind_reg, m_kind_next;

    logic               accept;
    logic [IDX_W-1:0]   in_row;
    logic [GRID_W-1:0]  in_bits;
    logic               in_range;
    logic [GRID_W-1:0]  below;
    logic [GRID_W-1:0]  new_row;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_row   = s_tdata[IDX_W-1:0];
    assign in_bits  = s_tdata[IDX_W +: GRID_W];
    assign in_range = int'(in_row) < GRID_H;

    // row that arrived from memory this cycle, dead when none was read or the row was never loaded
    assign below = rd_ok_reg ? rd_q_reg : '0;

    gol_row_engine u_engine (
        .clk      (clk),
        .above    (above_reg),
        .here     (here_reg),
        .below    (below),
        .next_row (new_row)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        above_next    = above_reg;
        here_next     = here_reg;
        wr_pend_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        rd_en         = 1'b0;
        rd_addr       = ADDR_W'(in_row);
        wr_en         = wr_pend_reg;
        wr_addr       = wr_addr_reg;
        wr_data       = new_row;
        res_data_next = res_data_reg;
        res_echo_next = res_echo_reg;
        res_kind_next = res_kind_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_echo_next   = m_echo_reg;
        m_kind_next   = m_kind_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_kind_next = s_tuser;
                    res_echo_next = '0;
                    res_data_next = '0;
                    case (op_t'(s_tuser))
                        OP_LOAD:
                        begin
                            wr_en         = in_range;
                            wr_addr       = ADDR_W'(in_row);
                            wr_data       = in_bits;
                            res_echo_next = in_row;
                            state_next    = ST_HOLD;
                        end
                        OP_READ:
                        begin
                            rd_en         = in_range;
                            res_echo_next = in_row;
                            state_next    = ST_READ;
                        end
                        OP_ADVANCE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            cnt_next   = '0;
                            above_next = '0;
                            here_next  = '0;
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_HOLD;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                // cnt_reg is the row arriving now; the engine works on row cnt_reg-1
                if (({1'b0, cnt_reg} + 1'b1) < (CNT_W+1)'(GRID_H))
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(cnt_reg + 1'b1);
                end
                above_next = here_reg;
                here_next  = below;
                if (cnt_reg != '0)
                begin
                    wr_pend_next = 1'b1;
                    wr_addr_next = ADDR_W'(cnt_reg - 1'b1);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(GRID_H))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_HOLD;
            end
            ST_READ:
            begin
                res_data_next = rd_ok_reg ? rd_q_reg : '0;
                state_next    = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_data_reg;
                    m_echo_next  = res_echo_reg;
                    m_kind_next  = res_kind_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            wr_pend_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            wr_pend_reg <= wr_pend_next;
            rd_ok_reg   <= rd_en && valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        above_reg    <= above_next;
        here_reg     <= here_next;
        wr_addr_reg  <= wr_addr_next;
        res_data_reg <= res_data_next;
        res_echo_reg <= res_echo_next;
        res_kind_reg <= res_kind_next;
        m_data_reg   <= m_data_next;
        m_echo_reg   <= m_echo_next;
        m_kind_reg   <= m_kind_next;
    end

    // row memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(TDATA_W - DATA_W - IDX_W)'(0), m_echo_reg, DATA_W'(m_data_reg)};
    assign m_tuser  = m_kind_reg;

    // engine writes only happen inside an advance
    a_wr_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg == ST_SWEEP || state_reg == ST_FLUSH))
        else $error("row write-back outside advance sweep");

    a_adv_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == OP_ADVANCE) |=> (state_reg == ST_SWEEP && cnt_reg == '0))
        else $error("advance did not start sweep at row zero");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (cnt_reg <= CNT_W'(GRID_H)))
        else $error("sweep counter past grid height");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD && (!m_valid_reg || m_tready)) |=> (m_tvalid && s_tready))
        else $error("held result not moved to output register");

endmodule

// ----- sv/gol_cell_lane.sv -----
// ----------------------------------------------------------------------------
// gol_cell_lane
// B3/S23 rule for one cell from its eight neighbors.
// ----------------------------------------------------------------------------
module gol_cell_lane
    import gol_pkg::*;
(
    input  logic [7:0] nbr,
    input  logic       self_alive,
    output logic       alive_next
);

    logic [3:0] n;

    always_comb
    begin
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(nbr[i]);
        end
        alive_next = (n == 4'd3) || (self_alive && (n == 4'd2));
    end

endmodule

// ----- sv/gol_row_engine.sv -----
// ----------------------------------------------------------------------------
// gol_row_engine
// One lane per column computes the next row; the lane outputs are merged
// into a registered row word.
// ----------------------------------------------------------------------------
module gol_row_engine
    import gol_pkg::*;
(
    input  logic              clk,
    input  logic [GRID_W-1:0] above,
    input  logic [GRID_W-1:0] here,
    input  logic [GRID_W-1:0] below,
    output logic [GRID_W-1:0] next_row
);

    // dead border column on each side
    logic [GRID_W+1:0] a_pad;
    logic [GRID_W+1:0] h_pad;
    logic [GRID_W+1:0] b_pad;
    logic [GRID_W-1:0] lane_alive;
    logic [GRID_W-1:0] next_row_reg;

    assign a_pad = {1'b0, above, 1'b0};
    assign h_pad = {1'b0, here, 1'b0};
    assign b_pad = {1'b0, below, 1'b0};

    for (genvar x = 0; x < GRID_W; x++)
    begin : g_lane
        gol_cell_lane u_lane (
            .nbr        ({a_pad[x], a_pad[x+1], a_pad[x+2],
                          h_pad[x], h_pad[x+2],
                          b_pad[x], b_pad[x+1], b_pad[x+2]}),
            .self_alive (here[x]),
            .alive_next (lane_alive[x])
        );
    end

    always_ff @(posedge clk)
    begin
        next_row_reg <= lane_alive;
    end

    assign next_row = next_row_reg;

endmodule

// ----- sim/life_grid_generation_step_tb.sv -----
// ----------------------------------------------------------------------------
// life_grid_generation_step_tb
// Self-checking bench for the life grid: rows are loaded, read back and the
// grid advanced under B3/S23 with dead border cells. A local grid model predicts
// every result word; both stream sides idle at random, with one calm stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module life_grid_generation_step_tb;
    import gol_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 4;
    localparam int DIRECTED_WORDS = 25;
    localparam int RANDOM_WORDS   = 800;
    localparam int IDLE_PCT       = 24;
    // advance is the slowest op; allow many times that with output stalls
    localparam int WATCHDOG_LIMIT = 16 * (GRID_H + 4);
    localparam int DRAIN_CYCLES   = GRID_H + 8;
    localparam logic [DATA_W-1:0] COL_MASK = {DATA_W{1'b1}} >> (DATA_W - GRID_W);

    typedef struct {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] bits;
    } grid_cmd_t;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [IDX_W-1:0]  echo;
        logic [OP_W-1:0]   kind;
    } grid_reply_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]    s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [OP_W-1:0]    m_tuser;

    grid_cmd_t         cmd_q[$];
    grid_reply_t       reply_q[$];
    logic [DATA_W-1:0] life_rows [GRID_H];
    int                accepted_cnt = 0;
    int                quiet_cycles = 0;
    int                errors       = 0;
    logic              calm;

    life_grid_generation_step u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // no idling on either side for a stretch in the middle of the run
    assign calm = (accepted_cnt >= 300) && (accepted_cnt < 450);

    // apply one command to the local grid and return the word it should produce
    function automatic grid_reply_t step_grid(input grid_cmd_t c);
        grid_reply_t       r;
        logic [DATA_W-1:0] next_gen [GRID_H];
        int                n;
        r.data = '0;
        r.echo = '0;
        r.kind = c.op;
        case (c.op)
            OP_LOAD:
            begin
                if (int'(c.idx) < GRID_H)
                    life_rows[c.idx] = c.bits & COL_MASK;
                r.echo = c.idx;
            end
            OP_ADVANCE:
            begin
                for (int y = 0; y < GRID_H; y++)
                begin
                    next_gen[y] = '0;
                    for (int x = 0; x < GRID_W; x++)
                    begin
                        n = 0;
                        for (int dy = -1; dy <= 1; dy++)
                            for (int dx = -1; dx <= 1; dx++)
                                if ((dy != 0 || dx != 0) && y + dy >= 0 && y + dy < GRID_H
                                    && x + dx >= 0 && x + dx < GRID_W
                                    && life_rows[y + dy][x + dx])
                                    n++;
                        next_gen[y][x] = (n == 3) || (n == 2 && life_rows[y][x]);
                    end
                end
                life_rows = next_gen;
            end
            OP_READ:
            begin
                if (int'(c.idx) < GRID_H)
                    r.data = life_rows[c.idx] & COL_MASK;
                r.echo = c.idx;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] random_cells(input int thin);
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        repeat (thin) v &= {$urandom, $urandom};
        return v;
    endfunction

    task automatic push_cmd(input op_t op, input int idx, input logic [DATA_W-1:0] bits);
        grid_cmd_t c;
        c.op   = op;
        c.idx  = IDX_W'(idx);
        c.bits = bits;
        cmd_q.push_back(c);
    endtask

    // source side: present queued commands, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        grid_cmd_t cur_cmd;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                reply_q.push_back(step_grid(cur_cmd));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= TDATA_W'({cur_cmd.bits, cur_cmd.idx});
                    s_tuser  <= cur_cmd.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // sink side: random backpressure, compare each result word in order
    always @(posedge clk or negedge rst_n)
    begin : reply_monitor
        grid_reply_t want;
        grid_reply_t got;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.data = m_tdata[DATA_W-1:0];
                got.echo = m_tdata[DATA_W +: IDX_W];
                got.kind = m_tuser;
                if (reply_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word: expected none, actual data=%h echo=%0d kind=%0d",
                             $time, got.data, got.echo, got.kind);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got.data !== want.data)
                    begin
                        errors++;
                        $display("%0t: row_data mismatch: expected %h, actual %h",
                                 $time, want.data, got.data);
                    end
                    if (got.echo !== want.echo)
                    begin
                        errors++;
                        $display("%0t: row_echo mismatch: expected %0d, actual %0d",
                                 $time, want.echo, got.echo);
                    end
                    if (got.kind !== want.kind)
                    begin
                        errors++;
                        $display("%0t: done_kind mismatch: expected %0d, actual %0d",
                                 $time, want.kind, got.kind);
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d commands and %0d results outstanding",
                         $time, cmd_q.size(), reply_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int base;
        int span;
        int thin;
        int gens;
        for (int y = 0; y < GRID_H; y++)
            life_rows[y] = '0;

        // directed: empty grid, full border rows, nop, blinker, glider on the edge
        push_cmd(OP_READ, 0, '0);
        push_cmd(OP_READ, 63, '1);
        push_cmd(OP_LOAD, 0, '1);
        push_cmd(OP_LOAD, 63, '1);
        push_cmd(OP_LOAD, 1, '0);
        push_cmd(OP_READ, 0, '0);
        push_cmd(OP_READ, 63, '0);
        push_cmd(OP_ADVANCE, 63, '1);
        push_cmd(OP_READ, 0, '0);
        push_cmd(OP_READ, 1, '0);
        push_cmd(OP_READ, 62, '0);
        push_cmd(OP_READ, 63, '0);
        push_cmd(OP_NOP, 63, '1);
        push_cmd(OP_NOP, 0, random_cells(0));
        push_cmd(OP_LOAD, 10, 64'h7 << 30);
        push_cmd(OP_LOAD, 20, 64'h1 << 62);
        push_cmd(OP_LOAD, 21, 64'h1 << 63);
        push_cmd(OP_LOAD, 22, 64'h7 << 61);
        push_cmd(OP_ADVANCE, 0, '0);
        push_cmd(OP_READ, 9, '0);
        push_cmd(OP_READ, 10, '0);
        push_cmd(OP_READ, 21, '0);
        push_cmd(OP_ADVANCE, 21, random_cells(0));
        push_cmd(OP_READ, 22, '0);
        push_cmd(OP_READ, 11, '0);

        // random: mostly load a band, advance a few times and read it back
        while (cmd_q.size() < DIRECTED_WORDS + RANDOM_WORDS)
        begin
            if ($urandom_range(99) < 70)
            begin
                base = $urandom_range(GRID_H - 1);
                span = $urandom_range(2, 8);
                thin = $urandom_range(0, 2);
                for (int k = 0; k < span; k++)
                    push_cmd(OP_LOAD, (base + k) % GRID_H, random_cells(thin));
                gens = $urandom_range(1, 3);
                repeat (gens)
                begin
                    push_cmd(OP_ADVANCE, $urandom_range(63), random_cells(0));
                    for (int k = -1; k <= span; k++)
                        push_cmd(OP_READ, (base + k + GRID_H) % GRID_H, random_cells(0));
                end
            end
            else
                push_cmd(op_t'($urandom_range(3)), $urandom_range(63), random_cells(0));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (cmd_q.size() != 0 || s_tvalid || reply_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
